// ===== hdl/jse_pkg.sv =====
// Package for the JSON string escaper: input selector codes, character codes,
// the job record passed from the front end to the emitter, and the hex digit helper.
// Used by every module of the block; depends on nothing.
package jse_pkg;

    localparam int JSE_FIFO_DEPTH = 4;

    localparam logic [1:0] FUNC_OPEN  = 2'd0;
    localparam logic [1:0] FUNC_DATA  = 2'd1;
    localparam logic [1:0] FUNC_CLOSE = 2'd2;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LOW_B     = 8'h62;
    localparam logic [7:0] CH_LOW_F     = 8'h66;
    localparam logic [7:0] CH_LOW_N     = 8'h6E;
    localparam logic [7:0] CH_LOW_R     = 8'h72;
    localparam logic [7:0] CH_LOW_T     = 8'h74;
    localparam logic [7:0] CH_LOW_U     = 8'h75;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TILDE     = 8'h7E;
    localparam logic [7:0] LEAD_THREE   = 8'hE0;

    // Kinds of work the emitter carries out.
    typedef enum logic [1:0] {
        JK_CHAR = 2'd0,   // one character, val[7:0]
        JK_ESC2 = 2'd1,   // backslash, then val[7:0]
        JK_UESC = 2'd2    // backslash, u, four hex digits of val
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [15:0] val;
    } t_job;

    localparam logic [2:0] STEP_LAST_CHAR = 3'd0;
    localparam logic [2:0] STEP_LAST_ESC2 = 3'd1;
    localparam logic [2:0] STEP_LAST_UESC = 3'd5;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
    endfunction

endpackage

// ===== hdl/jse_front.sv =====
// Front end of the JSON string escaper: accepts input items, tracks UTF-8
// sequences, holds the escape_unicode register and classifies each item into a job.
// Depends on jse_pkg.
module jse_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_func,
    input  logic [7:0]    i_data_byte,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_escape_unicode,
    input  logic          i_full,
    output logic          o_push,
    output jse_pkg::t_job o_job
);
    import jse_pkg::*;

    logic [1:0]  r_pend, n_pend;
    logic [15:0] r_accum, n_accum;
    logic        r_esc;
    logic        accept;

    assign o_ready     = !i_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && !i_full;

    always_comb begin
        n_pend  = r_pend;
        n_accum = r_accum;
        o_push  = 1'b0;
        o_job   = '{kind: JK_CHAR, val: 16'h0000};
        if (accept) begin
            case (i_func)
                FUNC_OPEN, FUNC_CLOSE: begin
                    n_pend  = 2'd0;
                    n_accum = 16'h0000;
                    o_push  = 1'b1;
                    o_job   = '{kind: JK_CHAR, val: {8'h00, CH_QUOTE}};
                end
                FUNC_DATA: begin
                    if (r_pend != 2'd0) begin
                        // Continuation byte: only its low six bits count.
                        n_accum = {r_accum[9:0], i_data_byte[5:0]};
                        n_pend  = r_pend - 2'd1;
                        if (r_pend == 2'd1) begin
                            o_push  = 1'b1;
                            o_job   = '{kind: JK_UESC, val: {r_accum[9:0], i_data_byte[5:0]}};
                            n_accum = 16'h0000;
                        end
                    end else begin
                        o_push = 1'b1;
                        case (i_data_byte)
                            CH_QUOTE:     o_job = '{kind: JK_ESC2, val: {8'h00, CH_QUOTE}};
                            CH_BACKSLASH: o_job = '{kind: JK_ESC2, val: {8'h00, CH_BACKSLASH}};
                            CH_BS:        o_job = '{kind: JK_ESC2, val: {8'h00, CH_LOW_B}};
                            CH_FF:        o_job = '{kind: JK_ESC2, val: {8'h00, CH_LOW_F}};
                            CH_LF:        o_job = '{kind: JK_ESC2, val: {8'h00, CH_LOW_N}};
                            CH_CR:        o_job = '{kind: JK_ESC2, val: {8'h00, CH_LOW_R}};
                            CH_TAB:       o_job = '{kind: JK_ESC2, val: {8'h00, CH_LOW_T}};
                            default: begin
                                if (!r_esc) begin
                                    o_job = '{kind: JK_CHAR, val: {8'h00, i_data_byte}};
                                end else if (!i_data_byte[7]) begin
                                    if (i_data_byte >= CH_SPACE && i_data_byte <= CH_TILDE) begin
                                        o_job = '{kind: JK_CHAR, val: {8'h00, i_data_byte}};
                                    end else begin
                                        o_job = '{kind: JK_UESC, val: {8'h00, i_data_byte}};
                                    end
                                end else if (i_data_byte < LEAD_THREE) begin
                                    // Two-byte lead, stray continuation bytes included.
                                    o_push  = 1'b0;
                                    n_pend  = 2'd1;
                                    n_accum = {11'h000, i_data_byte[4:0]};
                                end else begin
                                    // Three-byte lead; four-byte leads keep the low nibble too.
                                    o_push  = 1'b0;
                                    n_pend  = 2'd2;
                                    n_accum = {12'h000, i_data_byte[3:0]};
                                end
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 2'd0;
            r_accum <= 16'h0000;
            r_esc   <= 1'b0;
        end else begin
            r_pend  <= n_pend;
            r_accum <= n_accum;
            if (i_cfg_valid) begin
                r_esc <= i_cfg_escape_unicode;
            end
        end
    end

    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("front: pending count out of range");

    a_seq_end_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == FUNC_DATA && r_pend == 2'd1) |-> (o_push && o_job.kind == JK_UESC))
        else $error("front: finished sequence produced no escape job");

    a_no_push_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> accept)
        else $error("front: job pushed without an accepted item");

endmodule

// ===== hdl/jse_fifo.sv =====
// Short job queue between the front end and the emitter, built from flip-flops.
// Depends on jse_pkg only for the common import convention.
module jse_fifo #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    import jse_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_FULL);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("fifo: push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("fifo: pop while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_FULL)
        else $error("fifo: count beyond depth");

endmodule

// ===== hdl/jse_back.sv =====
// Emitter of the JSON string escaper: walks the job at the head of the queue one
// character per cycle, while the output is not stalled, into the output register. Depends on jse_pkg.
module jse_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  jse_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_out_char,
    output logic          o_run_last
);
    import jse_pkg::*;

    logic [2:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_char, n_out_char;
    logic       r_run_last, n_run_last;
    logic [2:0] last_step;
    logic [7:0] ch;
    logic       can_load;

    assign o_valid    = r_out_valid;
    assign o_out_char = r_out_char;
    assign o_run_last = r_run_last;
    assign can_load   = !r_out_valid || i_ready;

    always_comb begin
        case (i_job.kind)
            JK_CHAR: last_step = STEP_LAST_CHAR;
            JK_ESC2: last_step = STEP_LAST_ESC2;
            JK_UESC: last_step = STEP_LAST_UESC;
            default: last_step = STEP_LAST_CHAR;
        endcase
    end

    always_comb begin
        ch = CH_BACKSLASH;
        case (i_job.kind)
            JK_CHAR: ch = i_job.val[7:0];
            JK_ESC2: ch = (r_step == 3'd0) ? CH_BACKSLASH : i_job.val[7:0];
            JK_UESC: begin
                case (r_step)
                    3'd0:    ch = CH_BACKSLASH;
                    3'd1:    ch = CH_LOW_U;
                    3'd2:    ch = hex_char(i_job.val[15:12]);
                    3'd3:    ch = hex_char(i_job.val[11:8]);
                    3'd4:    ch = hex_char(i_job.val[7:4]);
                    default: ch = hex_char(i_job.val[3:0]);
                endcase
            end
            default: ch = CH_BACKSLASH;
        endcase
    end

    always_comb begin
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_run_last  = r_run_last;
        o_pop       = 1'b0;
        if (can_load) begin
            n_out_valid = !i_empty;
            if (!i_empty) begin
                n_out_char = ch;
                n_run_last = (r_step == last_step);
                if (r_step == last_step) begin
                    o_pop  = 1'b1;
                    n_step = 3'd0;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
        r_out_char <= n_out_char;
        r_run_last <= n_run_last;
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_LAST_UESC)
        else $error("back: step counter out of range");

    a_stall_holds_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_step == $past(r_step)))
        else $error("back: step advanced during an output stall");

    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_out_valid && r_run_last))
        else $error("back: job retired without a last character");

endmodule

// ===== hdl/json_string_escaper.sv =====
// JSON string escaper top level: front end, job queue and character emitter.
// The first character of an accepted item is written into the job queue, then loaded into the output register.
// Throughput: one item per cycle while each yields one character and the output is not stalled; an
// escaped item holds the emitter while it emits each of its characters, and the job queue absorbs bursts.
// Reset (synchronous, active low) clears the sequence state, escape_unicode, and the queue.
module json_string_escaper #(
    parameter int FIFO_DEPTH = jse_pkg::JSE_FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_func,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_run_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_escape_unicode
);
    import jse_pkg::*;

    localparam int JOB_W = $bits(t_job);

    t_job             push_job;
    t_job             head_job;
    logic [JOB_W-1:0] head_bits;
    logic             push, pop, full, empty;

    assign head_job = t_job'(head_bits);

    jse_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_func               (i_func),
        .i_data_byte          (i_data_byte),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_escape_unicode (i_cfg_escape_unicode),
        .i_full               (full),
        .o_push               (push),
        .o_job                (push_job)
    );

    jse_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_data  (head_bits),
        .o_empty (empty),
        .o_full  (full)
    );

    jse_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_job      (head_job),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_char (o_out_char),
        .o_run_last (o_run_last)
    );

endmodule
